@@ rtl/core/bqf_pkg.sv @@
// Shared types and constants for the biquad IIR filter block.
// Depends on nothing; imported by every module under rtl/core.
`default_nettype none

package bqf_pkg;

  // Coefficient format and default sample width
  localparam int COEF_W         = 16;
  localparam int FRAC_BITS      = 14;
  localparam int DATA_WIDTH_DEF = 16;

  // Headroom of the delay sums above the sample width
  localparam int STATE_EXTRA = 18;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_2 = 3'd4;

  // Coefficient values after reset (Q2.14)
  localparam logic signed [COEF_W-1:0] FF_COEF_0_RST = 16'sd16384;
  localparam logic signed [COEF_W-1:0] FF_COEF_1_RST = -16'sd32768;
  localparam logic signed [COEF_W-1:0] FF_COEF_2_RST = 16'sd16384;
  localparam logic signed [COEF_W-1:0] FB_COEF_1_RST = -16'sd25576;
  localparam logic signed [COEF_W-1:0] FB_COEF_2_RST = 16'sd10508;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture sample, form the three feedforward products
    logic calc;   // form the output sum, saturate, update output register
    logic fdbk;   // apply feedback and advance both delay sums
  } bqf_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/biquad_iir_filter.sv @@
// Top level of the biquad IIR filter (transposed direct form II, Q2.14).
// Depends on bqf_pkg, bqf_ctrl and bqf_dp.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | sink      | in_tvalid/in_tready  | in_tdata: sample_in
//  out_    | source    | out_tvalid/out_tready| out_tdata: sample_out
//  cfg_    | sink      | cfg_we (no wait)     | cfg_addr index, cfg_wdata coef
//
// Sequence: an input transaction registers the feedforward products, the output
//   step then updates the output register that presents the result, and the
//   feedback step follows; the next sample may be taken during that feedback step,
//   not before it, as the output step and the feedback step both use the registered output y.
// Reset: synchronous, active low; delay sums clear to zero and the
//   coefficients return to their default high-pass values.
// Stalls: a full output register that is not drained holds the output step;
//   input is taken again once that step completes.
`default_nettype none

module biquad_iir_filter #(
  parameter int DATA_WIDTH = bqf_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,   // [DATA_WIDTH-1:0] sample_in
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]          out_tdata,  // [DATA_WIDTH-1:0] sample_out
  // Coefficient write port
  input  wire logic                                cfg_we,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [bqf_pkg::COEF_W-1:0]          cfg_wdata
);
  import bqf_pkg::*;

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  bqf_cmd_t                     cmd;
  logic signed [DATA_WIDTH-1:0] sample_in;
  logic signed [DATA_WIDTH-1:0] sample_out;

  // Drop the byte padding above the sample
  assign sample_in = in_tdata[DATA_WIDTH-1:0];

  bqf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bqf_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (sample_in),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .sample_out (sample_out)
  );

  // Zero-fill the output up to whole bytes
  assign out_tdata = TDATA_W'($unsigned(sample_out));

endmodule

`default_nettype wire

@@ rtl/core/bqf_dp.sv @@
// Datapath of the biquad IIR filter: coefficient registers, multipliers,
// delay sums and output register. Depends on bqf_pkg.
`default_nettype none

module bqf_dp #(
  parameter int DATA_WIDTH = bqf_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bqf_pkg::bqf_cmd_t              cmd,
  input  wire logic signed [DATA_WIDTH-1:0]   sample_in,
  input  wire logic                           cfg_we,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [bqf_pkg::COEF_W-1:0]     cfg_wdata,
  output logic signed [DATA_WIDTH-1:0]        sample_out
);
  import bqf_pkg::*;

  localparam int PROD_W  = DATA_WIDTH + COEF_W;
  localparam int STATE_W = DATA_WIDTH + STATE_EXTRA;
  localparam int SH_W    = STATE_W - FRAC_BITS;
  localparam int TOP_W   = SH_W - DATA_WIDTH + 1;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [COEF_W-1:0]     ff0_r, ff1_r, ff2_r, fb1_r, fb2_r;
  logic signed [PROD_W-1:0]     p0_r, p1_r, p2_r;
  logic signed [STATE_W-1:0]    s1_r, s2_r;
  logic signed [DATA_WIDTH-1:0] y_r;

  logic signed [PROD_W-1:0]     p0_nxt, p1_nxt, p2_nxt;
  logic signed [PROD_W-1:0]     fb1_prod, fb2_prod;
  logic signed [STATE_W-1:0]    acc;
  logic signed [SH_W-1:0]       acc_sh;
  logic [TOP_W-1:0]             acc_top;
  logic signed [DATA_WIDTH-1:0] y_nxt;
  logic signed [STATE_W-1:0]    s1_nxt, s2_nxt;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff0_r <= FF_COEF_0_RST;
      ff1_r <= FF_COEF_1_RST;
      ff2_r <= FF_COEF_2_RST;
      fb1_r <= FB_COEF_1_RST;
      fb2_r <= FB_COEF_2_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FF_COEF_0: ff0_r <= cfg_wdata;
        CFG_FF_COEF_1: ff1_r <= cfg_wdata;
        CFG_FF_COEF_2: ff2_r <= cfg_wdata;
        CFG_FB_COEF_1: fb1_r <= cfg_wdata;
        CFG_FB_COEF_2: fb2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Feedforward products straight from the incoming sample
  assign p0_nxt = PROD_W'(sample_in) * PROD_W'(ff0_r);
  assign p1_nxt = PROD_W'(sample_in) * PROD_W'(ff1_r);
  assign p2_nxt = PROD_W'(sample_in) * PROD_W'(ff2_r);

  // Output sum, floor shift and saturation
  assign acc     = STATE_W'(p0_r) + s1_r;
  assign acc_sh  = SH_W'(acc >>> FRAC_BITS);
  assign acc_top = acc_sh[SH_W-1:DATA_WIDTH-1];

  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      y_nxt = acc_sh[DATA_WIDTH-1:0];
    end else if (acc_sh[SH_W-1]) begin
      y_nxt = SAT_MIN;
    end else begin
      y_nxt = SAT_MAX;
    end
  end

  // Feedback of the saturated output into the delay sums
  assign fb1_prod = PROD_W'(y_r) * PROD_W'(fb1_r);
  assign fb2_prod = PROD_W'(y_r) * PROD_W'(fb2_r);
  assign s1_nxt   = STATE_W'(p1_r) + s2_r - STATE_W'(fb1_prod);
  assign s2_nxt   = STATE_W'(p2_r) - STATE_W'(fb2_prod);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (cmd.calc) begin
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (cmd.fdbk) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign sample_out = y_r;

endmodule

`default_nettype wire

@@ rtl/core/bqf_ctrl.sv @@
// Controller of the biquad IIR filter: sequences load, output and feedback
// steps and owns the stream handshakes. Depends on bqf_pkg.
`default_nettype none

module bqf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output bqf_pkg::bqf_cmd_t      cmd
);
  import bqf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FDBK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   calc_go;

  // Take a new sample when idle or while the previous one finishes feedback
  assign in_tready = (state_r == ST_IDLE) || (state_r == ST_FDBK);
  // Output register free, or being emptied this cycle
  assign calc_go   = (state_r == ST_CALC) && (!out_valid_r || out_tready);

  assign cmd.load = in_tvalid && in_tready;
  assign cmd.calc = calc_go;
  assign cmd.fdbk = (state_r == ST_FDBK);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_go) begin
          state_nxt     = ST_FDBK;
          out_valid_nxt = 1'b1;
        end
      end
      ST_FDBK: begin
        state_nxt = cmd.load ? ST_CALC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A freshly computed output is presented in the next cycle
  a_calc_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> out_tvalid)
    else $error("computed output not presented");

  // Feedback always follows the output step of the same sample
  a_fdbk_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fdbk |-> $past(cmd.calc))
    else $error("feedback without preceding output step");

  // A blocked output keeps the controller waiting in the output step
  a_calc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) && out_valid_r && !out_tready |=> (state_r == ST_CALC))
    else $error("output step left while output register full");

  // No new sample is taken while the output step is pending
  a_no_load_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(state_r == ST_CALC))
    else $error("sample accepted during output step");

endmodule

`default_nettype wire
